### hdl/linear_adsr_envelope_defines.svh
`ifndef LINEAR_ADSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LAE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define LAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/lae_pkg.sv
package lae_pkg;

  localparam int GAIN_BITS = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd32768;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_RESET    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SLOPE,
    SQ_WAIT,
    SQ_MUL,
    SQ_DONE
  } seq_e;

  typedef enum logic [1:0] {
    SL_RISE,
    SL_FALL,
    SL_TAIL
  } slope_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/lae_if.sv
interface lae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] velocity;

  modport source (output valid, output cmd, output velocity, input ready);
  modport sink (input valid, input cmd, input velocity, output ready);
endinterface

interface lae_out_if #(
  parameter int LEVEL_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] amplitude;
  logic [2:0]            phase_code;

  modport source (output valid, output amplitude, output phase_code, input ready);
  modport sink (input valid, input amplitude, input phase_code, output ready);
endinterface

### hdl/lae_div.sv
module lae_div
  import lae_pkg::*;
#(
  parameter int NUM_W = 24,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output div_stat_t        stat_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hdl/lae_regs.sv
module lae_regs
  import lae_pkg::*;
#(
  parameter int LEVEL_BITS = 24,
  parameter int TIME_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  output logic [TIME_BITS-1:0]  attack_o,
  output logic [TIME_BITS-1:0]  decay_o,
  output logic [LEVEL_BITS-1:0] sustain_o,
  output logic [TIME_BITS-1:0]  release_o,
  output logic [15:0]           limit_o
);

  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << (LEVEL_BITS - 1);

  logic [TIME_BITS-1:0]  attack_q, decay_q, release_q;
  logic [LEVEL_BITS-1:0] sustain_q;
  logic [15:0]           limit_q;
  logic [2:0]            idx;
  logic                  wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= TIME_BITS'(44);
      decay_q   <= '0;
      sustain_q <= LEVEL_ONE;
      release_q <= TIME_BITS'(882);
      limit_q   <= 16'd22;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACK:  attack_q  <= pwdata[TIME_BITS-1:0];
        REG_DECAY:   decay_q   <= pwdata[TIME_BITS-1:0];
        REG_SUSTAIN: sustain_q <= pwdata[LEVEL_BITS-1:0];
        REG_RELEASE: release_q <= pwdata[TIME_BITS-1:0];
        REG_LIMIT:   limit_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = DATA_BITS'(attack_q);
      REG_DECAY:   prdata = DATA_BITS'(decay_q);
      REG_SUSTAIN: prdata = DATA_BITS'(sustain_q);
      REG_RELEASE: prdata = DATA_BITS'(release_q);
      REG_LIMIT:   prdata = DATA_BITS'(limit_q);
      default:     prdata = '0;
    endcase
  end

  assign attack_o  = attack_q;
  assign decay_o   = decay_q;
  assign sustain_o = sustain_q;
  assign release_o = release_q;
  assign limit_o   = limit_q;

endmodule

### hdl/linear_adsr_envelope.sv
// tick, reset and idle note-off: the request is registered, evaluated in EXEC, multiplied by
// the gain in MUL and moved to the output register from DONE; note-on, note-off and attack end
// also compute three slopes in one serial divider between EXEC and MUL, bypassed ones skip it
// one request in flight; a finished result waits in the output register
// async active-low reset: idle stage, level 0, gain 1.0, steps 0, registers to defaults
`include "linear_adsr_envelope_defines.svh"

module linear_adsr_envelope
  import lae_pkg::*;
#(
  parameter int LEVEL_BITS = 24,
  parameter int TIME_BITS  = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lae_in_if.sink               in_i,
  lae_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << (LEVEL_BITS - 1);
  localparam int PROD_W = LEVEL_BITS + GAIN_BITS;

  logic [TIME_BITS-1:0]  attack_t, decay_t, release_t;
  logic [LEVEL_BITS-1:0] sustain_r;
  logic [15:0]           limit_r;

  seq_e                  state_q, state_d;
  cmd_e                  cmd_q;
  logic [GAIN_BITS-1:0]  vel_q;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  stage_e                stage_q, stage_d;
  logic [GAIN_BITS-1:0]  gain_q, gain_d;
  logic [LEVEL_BITS-1:0] rise_q, rise_d, fall_q, fall_d, tail_q, tail_d;
  slope_e                sel_q, sel_d;
  logic [PROD_W-1:0]     prod_q;
  logic [LEVEL_BITS-1:0] amp_q;
  logic [2:0]            phase_q;
  logic                  out_valid_q;

  logic [LEVEL_BITS-1:0] sus;
  logic [LEVEL_BITS:0]   rise_sum;
  logic [LEVEL_BITS-1:0] ex_level;
  stage_e                ex_stage;
  logic [GAIN_BITS-1:0]  ex_gain;
  logic                  ex_recalc;

  logic [LEVEL_BITS-1:0] seg_dist;
  logic [TIME_BITS-1:0]  seg_time;
  logic                  bypass;
  logic [LEVEL_BITS-1:0] step_raw, step_fix;
  logic                  step_wr;
  logic                  last_slope;
  logic                  div_start;
  logic [LEVEL_BITS-1:0] div_quo;
  div_stat_t             div_stat;
  logic [PROD_W-1:0]     prod;
  logic                  out_load;

  lae_regs #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .attack_o (attack_t),
    .decay_o  (decay_t),
    .sustain_o(sustain_r),
    .release_o(release_t),
    .limit_o  (limit_r)
  );

  lae_div #(
    .NUM_W(LEVEL_BITS),
    .DEN_W(TIME_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (seg_dist),
    .den_i  (seg_time),
    .quo_o  (div_quo),
    .stat_o (div_stat)
  );

  assign sus      = (sustain_r > LEVEL_ONE) ? LEVEL_ONE : sustain_r;
  assign rise_sum = {1'b0, level_q} + {1'b0, rise_q};

  // command evaluation
  always_comb begin
    ex_level  = level_q;
    ex_stage  = stage_q;
    ex_gain   = gain_q;
    ex_recalc = 1'b0;
    case (cmd_q)
      CMD_TICK: begin
        case (stage_q)
          ST_ATTACK: begin
            if (rise_sum >= {1'b0, LEVEL_ONE}) begin
              ex_level  = LEVEL_ONE;
              ex_stage  = ST_DECAY;
              ex_recalc = 1'b1;
            end else begin
              ex_level = rise_sum[LEVEL_BITS-1:0];
            end
          end
          ST_DECAY: begin
            if (fall_q >= level_q || (level_q - fall_q) <= sus) begin
              ex_level = sus;
              ex_stage = ST_SUSTAIN;
            end else begin
              ex_level = level_q - fall_q;
            end
          end
          ST_SUSTAIN: begin
            ex_level = sus;
          end
          ST_RELEASE: begin
            if (tail_q >= level_q) begin
              ex_level = '0;
              ex_stage = ST_IDLE;
            end else begin
              ex_level = level_q - tail_q;
            end
          end
          default: begin
            ex_level = '0;
            ex_stage = ST_IDLE;
          end
        endcase
      end
      CMD_NOTE_ON: begin
        ex_gain   = (vel_q > GAIN_ONE) ? GAIN_ONE : vel_q;
        ex_stage  = ST_ATTACK;
        ex_recalc = 1'b1;
      end
      CMD_NOTE_OFF: begin
        if (stage_q != ST_IDLE) begin
          ex_stage  = ST_RELEASE;
          ex_recalc = 1'b1;
        end
      end
      default: begin
        ex_level = '0;
        ex_gain  = GAIN_ONE;
        ex_stage = ST_IDLE;
      end
    endcase
  end

  // slope operand selection
  always_comb begin
    case (sel_q)
      SL_RISE: begin
        seg_dist = LEVEL_ONE - level_q;
        seg_time = attack_t;
      end
      SL_FALL: begin
        seg_dist = LEVEL_ONE - sus;
        seg_time = decay_t;
      end
      default: begin
        seg_dist = level_q;
        seg_time = release_t;
      end
    endcase
    bypass     = (seg_time <= TIME_BITS'(limit_r)) || (seg_time == '0);
    step_raw   = bypass ? seg_dist : div_quo;
    step_fix   = (step_raw == '0) ? LEVEL_BITS'(1) : step_raw;
    last_slope = (sel_q == SL_TAIL);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (in_i.valid) begin
          state_d = SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        state_d = ex_recalc ? SQ_SLOPE : SQ_MUL;
      end
      SQ_SLOPE: begin
        if (!bypass) begin
          state_d = SQ_WAIT;
        end else if (last_slope) begin
          state_d = SQ_MUL;
        end
      end
      SQ_WAIT: begin
        if (div_stat.done) begin
          state_d = last_slope ? SQ_MUL : SQ_SLOPE;
        end
      end
      SQ_MUL: begin
        state_d = SQ_DONE;
      end
      SQ_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  // sequencer outputs and state updates
  always_comb begin
    level_d   = level_q;
    stage_d   = stage_q;
    gain_d    = gain_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    tail_d    = tail_q;
    sel_d     = sel_q;
    div_start = 1'b0;
    step_wr   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      SQ_EXEC: begin
        level_d = ex_level;
        stage_d = ex_stage;
        gain_d  = ex_gain;
        sel_d   = SL_RISE;
      end
      SQ_SLOPE: begin
        div_start = !bypass;
        step_wr   = bypass;
      end
      SQ_WAIT: begin
        step_wr = div_stat.done;
      end
      SQ_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
    if (step_wr) begin
      case (sel_q)
        SL_RISE: begin
          rise_d = step_fix;
          sel_d  = SL_FALL;
        end
        SL_FALL: begin
          fall_d = step_fix;
          sel_d  = SL_TAIL;
        end
        default: begin
          tail_d = step_fix;
        end
      endcase
    end
  end

  assign prod = PROD_W'(level_q) * PROD_W'(gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      level_q     <= '0;
      stage_q     <= ST_IDLE;
      gain_q      <= GAIN_ONE;
      rise_q      <= '0;
      fall_q      <= '0;
      tail_q      <= '0;
      sel_q       <= SL_RISE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      stage_q <= stage_d;
      gain_q  <= gain_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      tail_q  <= tail_d;
      sel_q   <= sel_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SQ_IDLE && in_i.valid) begin
      cmd_q <= cmd_e'(in_i.cmd);
      vel_q <= in_i.velocity;
    end
    if (state_q == SQ_MUL) begin
      prod_q <= prod;
    end
    if (out_load) begin
      amp_q   <= prod_q[LEVEL_BITS+14:15];
      phase_q <= stage_q;
    end
  end

  assign in_i.ready       = (state_q == SQ_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.amplitude  = amp_q;
  assign out_o.phase_code = phase_q;

  // level stays within unity
  `LAE_ASSERT_IMPL(a_level_range, clk_i, rst_ni, 1'b1, level_q <= LEVEL_ONE)
  // an accepted request blocks the input until its work is done
  `LAE_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // the divider is only started while idle
  `LAE_ASSERT_IMPL(a_div_free, clk_i, rst_ni, div_start, !div_stat.busy)
  // results leave the sequencer only from its final state
  `LAE_ASSERT_IMPL(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == SQ_DONE))

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lae_pkg::*;

  localparam logic [23:0] UNITY = 24'h800000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_ITEMS = 145;

  typedef enum int {
    GAP_NONE,
    GAP_SENDER,
    GAP_RECEIVER,
    GAP_BOTH
  } gap_mode_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] velocity;
  } envelope_cmd_t;

  typedef struct packed {
    logic [23:0] amplitude;
    logic [2:0]  phase_code;
  } envelope_out_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  lae_in_if in_if ();
  lae_out_if #(.LEVEL_BITS(24)) out_if ();

  linear_adsr_envelope #(
    .LEVEL_BITS(24),
    .TIME_BITS (24)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // envelope state mirrored by the predictor
  logic [23:0] cfg_attack;
  logic [23:0] cfg_decay;
  logic [23:0] cfg_sustain;
  logic [23:0] cfg_release;
  logic [15:0] cfg_limit;
  logic [23:0] env_level;
  stage_e      env_stage;
  logic [15:0] env_gain;
  logic [23:0] rise_step;
  logic [23:0] fall_step;
  logic [23:0] tail_step;

  envelope_cmd_t pending_cmds[$];
  envelope_out_t amp_expect_q[$];
  gap_mode_e     gap_mode;
  bit            request_accepted;
  bit            hold_request;
  int            hold_left;
  int            quiet_cycles;
  int            fail_count;
  int            queued;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [23:0] sustain_target();
    return (cfg_sustain > UNITY) ? UNITY : cfg_sustain;
  endfunction

  function automatic logic [23:0] slope_of(logic [23:0] remain, logic [23:0] span);
    logic [23:0] q;
    if (span <= 24'(cfg_limit) || span == 24'd0) begin
      q = remain;
    end else begin
      q = remain / span;
    end
    return (q == 24'd0) ? 24'd1 : q;
  endfunction

  function automatic void refresh_slopes();
    rise_step = slope_of(UNITY - env_level, cfg_attack);
    fall_step = slope_of(UNITY - sustain_target(), cfg_decay);
    tail_step = slope_of(env_level, cfg_release);
  endfunction

  function automatic envelope_out_t advance_envelope(envelope_cmd_t req);
    logic [24:0]   sum;
    logic [23:0]   sus;
    logic [39:0]   prod;
    envelope_out_t res;
    sus = sustain_target();
    case (req.cmd)
      CMD_TICK: begin
        case (env_stage)
          ST_ATTACK: begin
            sum = {1'b0, env_level} + {1'b0, rise_step};
            if (sum >= {1'b0, UNITY}) begin
              env_level = UNITY;
              env_stage = ST_DECAY;
              refresh_slopes();
            end else begin
              env_level = sum[23:0];
            end
          end
          ST_DECAY: begin
            if (fall_step >= env_level || env_level - fall_step <= sus) begin
              env_level = sus;
              env_stage = ST_SUSTAIN;
            end else begin
              env_level = env_level - fall_step;
            end
          end
          ST_SUSTAIN: begin
            env_level = sus;
          end
          ST_RELEASE: begin
            if (tail_step >= env_level) begin
              env_level = 24'd0;
              env_stage = ST_IDLE;
            end else begin
              env_level = env_level - tail_step;
            end
          end
          default: begin
            env_level = 24'd0;
            env_stage = ST_IDLE;
          end
        endcase
      end
      CMD_NOTE_ON: begin
        env_gain = (req.velocity > GAIN_ONE) ? GAIN_ONE : req.velocity;
        env_stage = ST_ATTACK;
        refresh_slopes();
      end
      CMD_NOTE_OFF: begin
        if (env_stage != ST_IDLE) begin
          env_stage = ST_RELEASE;
          refresh_slopes();
        end
      end
      default: begin
        env_level = 24'd0;
        env_gain = GAIN_ONE;
        env_stage = ST_IDLE;
      end
    endcase
    prod = 40'(env_level) * 40'(env_gain);
    res.amplitude = prod[38:15];
    res.phase_code = env_stage;
    return res;
  endfunction

  function automatic bit sender_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    return (gap_mode == GAP_SENDER && roll < 55) || (gap_mode == GAP_BOTH && roll < 10);
  endfunction

  function automatic bit receiver_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    return (gap_mode == GAP_RECEIVER && roll < 55) || (gap_mode == GAP_BOTH && roll < 10);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    envelope_cmd_t req;
    if (rst_ni && (!in_if.valid || request_accepted)) begin
      request_accepted = 1'b0;
      if (pending_cmds.size() != 0 && !sender_gap()) begin
        req = pending_cmds.pop_front();
        in_if.valid <= 1'b1;
        in_if.cmd <= req.cmd;
        in_if.velocity <= req.velocity;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with long hold-off
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && !receiver_gap();
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    envelope_cmd_t req;
    envelope_out_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_if.valid && in_if.ready) begin
        req.cmd = cmd_e'(in_if.cmd);
        req.velocity = in_if.velocity;
        amp_expect_q.push_back(advance_envelope(req));
        request_accepted = 1'b1;
        quiet_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        if (amp_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: amplitude %h phase %0d", $time,
                   out_if.amplitude, out_if.phase_code);
        end else begin
          want = amp_expect_q.pop_front();
          if (out_if.amplitude !== want.amplitude) begin
            fail_count++;
            $display("%0t amplitude mismatch: expected %h actual %h", $time,
                     want.amplitude, out_if.amplitude);
          end
          if (out_if.phase_code !== want.phase_code) begin
            fail_count++;
            $display("%0t phase mismatch: expected %0d actual %0d", $time,
                     want.phase_code, out_if.phase_code);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ATTACK:  cfg_attack = value[23:0];
      REG_DECAY:   cfg_decay = value[23:0];
      REG_SUSTAIN: cfg_sustain = value[23:0];
      REG_RELEASE: cfg_release = value[23:0];
      REG_LIMIT:   cfg_limit = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_envelope(logic [23:0] atk, logic [23:0] dec, logic [23:0] sus,
                                  logic [23:0] rel, logic [15:0] lim);
    apb_write(REG_ATTACK, 32'(atk));
    apb_write(REG_DECAY, 32'(dec));
    apb_write(REG_SUSTAIN, 32'(sus));
    apb_write(REG_RELEASE, 32'(rel));
    apb_write(REG_LIMIT, 32'(lim));
  endtask

  task automatic push_item(cmd_e cmd, logic [15:0] velocity);
    envelope_cmd_t req;
    req.cmd = cmd;
    req.velocity = velocity;
    pending_cmds.push_back(req);
    queued++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_item(CMD_TICK, 16'($urandom_range(65535)));
  endtask

  function automatic logic [15:0] random_velocity();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return GAIN_ONE;
    if (roll < 15) return 16'd0;
    return 16'($urandom_range(1, 32767));
  endfunction

  task automatic queue_phrase();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) push_item(cmd_e'($urandom_range(3)), random_velocity());
    end else begin
      push_item(CMD_NOTE_ON, random_velocity());
      push_ticks($urandom_range(0, 50));
      if ($urandom_range(99) < 20) begin
        push_item(CMD_NOTE_ON, random_velocity());
        push_ticks($urandom_range(0, 30));
      end
      if ($urandom_range(99) < 8) begin
        push_item(CMD_RESET, random_velocity());
      end else begin
        push_item(CMD_NOTE_OFF, random_velocity());
        push_ticks($urandom_range(0, 50));
      end
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_if.valid || amp_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.velocity = 16'd0;
    out_if.ready = 1'b0;
    cfg_attack = 24'd44;
    cfg_decay = 24'd0;
    cfg_sustain = UNITY;
    cfg_release = 24'd882;
    cfg_limit = 16'd22;
    env_level = 24'd0;
    env_stage = ST_IDLE;
    env_gain = GAIN_ONE;
    rise_step = 24'd0;
    fall_step = 24'd0;
    tail_step = 24'd0;
    gap_mode = GAP_NONE;
    request_accepted = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    fail_count = 0;
    queued = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle commands, zero-length segments, minimum step, retrigger
    program_envelope(24'd2, 24'd4, 24'h400000, 24'd0, 16'd3);
    push_item(CMD_NOTE_OFF, 16'd0);
    push_item(CMD_TICK, 16'hffff);
    push_item(CMD_NOTE_ON, GAIN_ONE);
    push_item(CMD_NOTE_OFF, 16'd0);
    push_ticks(1);
    push_item(CMD_NOTE_ON, GAIN_ONE);
    push_ticks(1);
    push_item(CMD_NOTE_ON, 16'd0);
    push_ticks(2);
    push_item(CMD_NOTE_ON, 16'd1);
    push_ticks(6);
    push_item(CMD_NOTE_OFF, 16'h7fff);
    push_ticks(1);
    push_item(CMD_NOTE_ON, 16'hffff);
    push_ticks(1);
    push_item(CMD_NOTE_ON, 16'h5555);
    push_item(CMD_RESET, 16'haaaa);
    push_item(CMD_NOTE_ON, 16'd32767);
    push_ticks(6);
    drain();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: program_envelope(24'd44, 24'd0, UNITY, 24'd882, 16'd22);
        2: program_envelope(24'hffffff, 24'hffffff, 24'd0, 24'hffffff, 16'd0);
        3: program_envelope(24'($urandom_range(65535)), 24'($urandom_range(65535)),
                            24'd0, 24'($urandom_range(65535)), 16'hffff);
        default: begin
          program_envelope(($urandom_range(99) < 20) ? 24'($urandom_range(24'hffffff))
                                                    : 24'($urandom_range(40)),
                           24'($urandom_range(40)), 24'($urandom_range(UNITY)),
                           24'($urandom_range(40)), 16'($urandom_range(10)));
        end
      endcase
      gap_mode = (p == 1) ? GAP_NONE : gap_mode_e'(p % 4);
      if (p == 2 || p == 6) hold_request = 1'b1;
      // sustain changes take effect at once while sustaining
      push_ticks(2);
      queued = 0;
      while (queued < PHASE_ITEMS) queue_phrase();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && amp_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/lae_pkg.sv
hdl/lae_if.sv
hdl/lae_div.sv
hdl/lae_regs.sv
hdl/linear_adsr_envelope.sv
dv/testbench.sv
